[hdl/cau_pkg.sv]
// Shared types and codes for the complex arithmetic unit.
// Depends on nothing; every other file imports it.
package cau_pkg;

    localparam int OP_W = 3;
    localparam int ST_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 3'd0,
        OP_SUB     = 3'd1,
        OP_MUL     = 3'd2,
        OP_DIV     = 3'd3,
        OP_MAG     = 3'd4,
        OP_LESS    = 3'd5,
        OP_GREATER = 3'd6
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_OVF  = 2'd2
    } t_status;

    typedef struct packed {
        t_op  op;
        logic ovf;
        logic dz;
        logic neg_re;
        logic neg_im;
        logic dovf_re;
        logic dovf_im;
        logic truth;
    } t_ctl;

endpackage

[hdl/cau_in_if.sv]
// Operand channel of the complex arithmetic unit.
// Depends on cau_pkg for the operation code width.
interface cau_in_if
    import cau_pkg::*;
#(
    parameter int DW = 32
) ();
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      operation;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [DW-1:0] b_re;
    logic signed [DW-1:0] b_im;

    modport source (output valid, operation, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, operation, a_re, a_im, b_re, b_im, output ready);
endinterface

[hdl/cau_out_if.sv]
// Result channel of the complex arithmetic unit.
// Depends on cau_pkg for the status width.
interface cau_out_if
    import cau_pkg::*;
#(
    parameter int DW = 32
) ();
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] res_re;
    logic signed [DW-1:0] res_im;
    logic                 truth;
    logic [ST_W-1:0]      status;

    modport source (output valid, res_re, res_im, truth, status, input ready);
    modport sink   (input valid, res_re, res_im, truth, status, output ready);
endinterface

[hdl/cau_front.sv]
// Front pipeline: products, sums, add/sub/mul saturation, compares, div/root setup.
// Depends on cau_pkg; feeds the first cau_cell.
module cau_front
    import cau_pkg::*;
#(
    parameter int DW = 32,
    parameter int FB = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [OP_W-1:0]       i_op,
    input  logic signed [DW-1:0]  i_a_re,
    input  logic signed [DW-1:0]  i_a_im,
    input  logic signed [DW-1:0]  i_b_re,
    input  logic signed [DW-1:0]  i_b_im,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_ctl                  o_ctl,
    output logic [DW-1:0]         o_res_re,
    output logic [DW-1:0]         o_res_im,
    output logic [3*DW+FB:0]      o_drem_re,
    output logic [3*DW+FB:0]      o_drem_im,
    output logic [2*DW-1:0]       o_den,
    output logic [2*DW:0]         o_srem
);
    localparam int PW = 2 * DW;
    localparam int XW = 3 * DW + FB + 1;
    localparam int SW = 2 * DW + 1;
    localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

    logic rdy1, rdy2, rdy3, rdy4;

    // Stage 1: the eight products.
    logic                 r1_v;
    t_op                  r1_op;
    logic [DW-1:0]        r1_a_re, r1_a_im, r1_b_re, r1_b_im;
    logic signed [PW-1:0] r1_p_rr, r1_p_ii, r1_p_ri, r1_p_ir;
    logic signed [PW-1:0] r1_q_ar, r1_q_ai, r1_q_br, r1_q_bi;
    logic signed [PW-1:0] n1_p_rr, n1_p_ii, n1_p_ri, n1_p_ir;
    logic signed [PW-1:0] n1_q_ar, n1_q_ai, n1_q_br, n1_q_bi;

    assign n1_p_rr = i_a_re * i_b_re;
    assign n1_p_ii = i_a_im * i_b_im;
    assign n1_p_ri = i_a_re * i_b_im;
    assign n1_p_ir = i_a_im * i_b_re;
    assign n1_q_ar = i_a_re * i_a_re;
    assign n1_q_ai = i_a_im * i_a_im;
    assign n1_q_br = i_b_re * i_b_re;
    assign n1_q_bi = i_b_im * i_b_im;

    assign rdy1    = !r1_v || rdy2;
    assign o_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (rdy1) begin
            r1_v <= i_valid;
        end
        if (i_valid && rdy1) begin
            r1_op   <= t_op'(i_op);
            r1_a_re <= i_a_re;
            r1_a_im <= i_a_im;
            r1_b_re <= i_b_re;
            r1_b_im <= i_b_im;
            r1_p_rr <= n1_p_rr;
            r1_p_ii <= n1_p_ii;
            r1_p_ri <= n1_p_ri;
            r1_p_ir <= n1_p_ir;
            r1_q_ar <= n1_q_ar;
            r1_q_ai <= n1_q_ai;
            r1_q_br <= n1_q_br;
            r1_q_bi <= n1_q_bi;
        end
    end

    // Stage 2: sums and differences.
    logic                 r2_v;
    t_op                  r2_op;
    logic signed [DW:0]   r2_s_re, r2_s_im;
    logic signed [PW:0]   r2_m_re, r2_m_im, r2_nr, r2_ni;
    logic [PW-1:0]        r2_sa, r2_sb;
    logic [DW:0]          n2_s_re, n2_s_im;

    always_comb begin
        if (r1_op == OP_SUB) begin
            n2_s_re = {r1_a_re[DW-1], r1_a_re} - {r1_b_re[DW-1], r1_b_re};
            n2_s_im = {r1_a_im[DW-1], r1_a_im} - {r1_b_im[DW-1], r1_b_im};
        end else begin
            n2_s_re = {r1_a_re[DW-1], r1_a_re} + {r1_b_re[DW-1], r1_b_re};
            n2_s_im = {r1_a_im[DW-1], r1_a_im} + {r1_b_im[DW-1], r1_b_im};
        end
    end

    assign rdy2 = !r2_v || rdy3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (rdy2) begin
            r2_v <= r1_v;
        end
        if (r1_v && rdy2) begin
            r2_op   <= r1_op;
            r2_s_re <= n2_s_re;
            r2_s_im <= n2_s_im;
            r2_m_re <= {r1_p_rr[PW-1], r1_p_rr} - {r1_p_ii[PW-1], r1_p_ii};
            r2_m_im <= {r1_p_ri[PW-1], r1_p_ri} + {r1_p_ir[PW-1], r1_p_ir};
            r2_nr   <= {r1_p_rr[PW-1], r1_p_rr} + {r1_p_ii[PW-1], r1_p_ii};
            r2_ni   <= {r1_p_ir[PW-1], r1_p_ir} - {r1_p_ri[PW-1], r1_p_ri};
            r2_sa   <= r1_q_ar + r1_q_ai;
            r2_sb   <= r1_q_br + r1_q_bi;
        end
    end

    // Stage 3: saturation, numerator magnitudes, comparison.
    logic               r3_v;
    t_ctl               r3_ctl;
    logic [DW-1:0]      r3_res_re, r3_res_im;
    logic [PW-1:0]      r3_nmag_re, r3_nmag_im, r3_sa, r3_sb;
    logic signed [PW:0] n3_sh_re, n3_sh_im;
    logic               n3_aov_re, n3_aov_im, n3_mov_re, n3_mov_im;
    logic [DW-1:0]      n3_add_re, n3_add_im, n3_mul_re, n3_mul_im;
    t_ctl               n3_ctl;
    logic [DW-1:0]      n3_res_re, n3_res_im;

    assign n3_sh_re  = r2_m_re >>> FB;
    assign n3_sh_im  = r2_m_im >>> FB;
    assign n3_aov_re = r2_s_re[DW] != r2_s_re[DW-1];
    assign n3_aov_im = r2_s_im[DW] != r2_s_im[DW-1];
    assign n3_mov_re = !((&n3_sh_re[PW:DW-1]) || !(|n3_sh_re[PW:DW-1]));
    assign n3_mov_im = !((&n3_sh_im[PW:DW-1]) || !(|n3_sh_im[PW:DW-1]));
    assign n3_add_re = n3_aov_re ? (r2_s_re[DW] ? MINV : MAXV) : r2_s_re[DW-1:0];
    assign n3_add_im = n3_aov_im ? (r2_s_im[DW] ? MINV : MAXV) : r2_s_im[DW-1:0];
    assign n3_mul_re = n3_mov_re ? (n3_sh_re[PW] ? MINV : MAXV) : n3_sh_re[DW-1:0];
    assign n3_mul_im = n3_mov_im ? (n3_sh_im[PW] ? MINV : MAXV) : n3_sh_im[DW-1:0];

    always_comb begin
        n3_ctl        = '0;
        n3_ctl.op     = r2_op;
        n3_ctl.neg_re = r2_nr[PW];
        n3_ctl.neg_im = r2_ni[PW];
        n3_ctl.dz     = (r2_op == OP_DIV) && (r2_sb == '0);
        n3_res_re     = '0;
        n3_res_im     = '0;
        case (r2_op)
            OP_ADD, OP_SUB: begin
                n3_res_re  = n3_add_re;
                n3_res_im  = n3_add_im;
                n3_ctl.ovf = n3_aov_re || n3_aov_im;
            end
            OP_MUL: begin
                n3_res_re  = n3_mul_re;
                n3_res_im  = n3_mul_im;
                n3_ctl.ovf = n3_mov_re || n3_mov_im;
            end
            OP_LESS:    n3_ctl.truth = r2_sa < r2_sb;
            OP_GREATER: n3_ctl.truth = r2_sb < r2_sa;
            default: begin
            end
        endcase
    end

    assign rdy3 = !r3_v || rdy4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (rdy3) begin
            r3_v <= r2_v;
        end
        if (r2_v && rdy3) begin
            r3_ctl     <= n3_ctl;
            r3_res_re  <= n3_res_re;
            r3_res_im  <= n3_res_im;
            r3_nmag_re <= r2_nr[PW] ? PW'(-r2_nr) : r2_nr[PW-1:0];
            r3_nmag_im <= r2_ni[PW] ? PW'(-r2_ni) : r2_ni[PW-1:0];
            r3_sa      <= r2_sa;
            r3_sb      <= r2_sb;
        end
    end

    // Stage 4: scaled numerators and the quotient range check.
    logic          r4_v;
    t_ctl          r4_ctl;
    logic [XW-1:0] n4_num_re, n4_num_im, n4_lim;
    t_ctl          n4_ctl;

    assign n4_num_re = XW'(r3_nmag_re) << FB;
    assign n4_num_im = XW'(r3_nmag_im) << FB;
    assign n4_lim    = XW'(r3_sb) << DW;

    always_comb begin
        n4_ctl         = r3_ctl;
        n4_ctl.dovf_re = n4_num_re >= n4_lim;
        n4_ctl.dovf_im = n4_num_im >= n4_lim;
    end

    assign rdy4 = !r4_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (rdy4) begin
            r4_v <= r3_v;
        end
        if (r3_v && rdy4) begin
            r4_ctl    <= n4_ctl;
            o_res_re  <= r3_res_re;
            o_res_im  <= r3_res_im;
            o_drem_re <= n4_num_re;
            o_drem_im <= n4_num_im;
            o_den     <= r3_sb;
            o_srem    <= SW'(r3_sa);
        end
    end

    assign o_valid = r4_v;
    assign o_ctl   = r4_ctl;

endmodule

[hdl/cau_cell.sv]
// One cell of the quotient and square-root chain: settles one result bit.
// Depends on cau_pkg; chained by complex_arith_unit_core.
module cau_cell
    import cau_pkg::*;
#(
    parameter int DW  = 32,
    parameter int FB  = 16,
    parameter int BIT = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_ctl               i_ctl,
    input  logic [DW-1:0]      i_res_re,
    input  logic [DW-1:0]      i_res_im,
    input  logic [3*DW+FB:0]   i_drem_re,
    input  logic [3*DW+FB:0]   i_drem_im,
    input  logic [2*DW-1:0]    i_den,
    input  logic [DW-1:0]      i_dq_re,
    input  logic [DW-1:0]      i_dq_im,
    input  logic [2*DW:0]      i_srem,
    input  logic [DW-1:0]      i_sroot,
    output logic               o_valid,
    input  logic               i_ready,
    output t_ctl               o_ctl,
    output logic [DW-1:0]      o_res_re,
    output logic [DW-1:0]      o_res_im,
    output logic [3*DW+FB:0]   o_drem_re,
    output logic [3*DW+FB:0]   o_drem_im,
    output logic [2*DW-1:0]    o_den,
    output logic [DW-1:0]      o_dq_re,
    output logic [DW-1:0]      o_dq_im,
    output logic [2*DW:0]      o_srem,
    output logic [DW-1:0]      o_sroot
);
    localparam int XW = 3 * DW + FB + 1;
    localparam int SW = 2 * DW + 1;
    localparam logic [DW-1:0] QBIT = DW'(1) << BIT;

    logic          r_v;
    logic [XW-1:0] n_dsh;
    logic [SW-1:0] n_trial;
    logic          n_ge_re, n_ge_im, n_ge_s;

    assign n_dsh   = XW'(i_den) << BIT;
    assign n_trial = (SW'(i_sroot) << (BIT + 1)) + (SW'(1) << (2 * BIT));
    assign n_ge_re = i_drem_re >= n_dsh;
    assign n_ge_im = i_drem_im >= n_dsh;
    assign n_ge_s  = i_srem >= n_trial;

    assign o_ready = !r_v || i_ready;
    assign o_valid = r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
        if (i_valid && o_ready) begin
            o_ctl     <= i_ctl;
            o_res_re  <= i_res_re;
            o_res_im  <= i_res_im;
            o_den     <= i_den;
            o_drem_re <= n_ge_re ? i_drem_re - n_dsh : i_drem_re;
            o_drem_im <= n_ge_im ? i_drem_im - n_dsh : i_drem_im;
            o_dq_re   <= n_ge_re ? (i_dq_re | QBIT) : i_dq_re;
            o_dq_im   <= n_ge_im ? (i_dq_im | QBIT) : i_dq_im;
            o_srem    <= n_ge_s ? i_srem - n_trial : i_srem;
            o_sroot   <= n_ge_s ? (i_sroot | QBIT) : i_sroot;
        end
    end

endmodule

[hdl/complex_arith_unit_core.sv]
// Top level of the complex arithmetic unit: front pipeline, cell chain, output stage.
// Depends on cau_pkg, cau_in_if, cau_out_if, cau_front and cau_cell.
//
//   Channel  | Dir | Payload                            | Handshake
//   i_in     | in  | operation, a_re, a_im, b_re, b_im  | valid/ready
//   o_out    | out | res_re, res_im, truth, status      | valid/ready
//
// One transfer per cycle is taken and given in steady flow while o_out is ready.
// The pipeline is four front stages, one cell per quotient and root bit,
// and the output register.
// Every stage holds its item under a stall and takes a new one when it empties.
// Reset clears only the stage valid flags.
module complex_arith_unit_core
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cau_in_if.sink     i_in,
    cau_out_if.source  o_out
);
    localparam int DW = DATA_WIDTH;
    localparam int PW = 2 * DW;
    localparam int XW = 3 * DW + FRAC_BITS + 1;
    localparam int SW = 2 * DW + 1;
    localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

    logic          w_v       [0:DW];
    logic          w_rdy     [0:DW];
    t_ctl          w_ctl     [0:DW];
    logic [DW-1:0] w_res_re  [0:DW];
    logic [DW-1:0] w_res_im  [0:DW];
    logic [XW-1:0] w_drem_re [0:DW];
    logic [XW-1:0] w_drem_im [0:DW];
    logic [PW-1:0] w_den     [0:DW];
    logic [DW-1:0] w_dq_re   [0:DW];
    logic [DW-1:0] w_dq_im   [0:DW];
    logic [SW-1:0] w_srem    [0:DW];
    logic [DW-1:0] w_sroot   [0:DW];

    cau_front #(.DW(DW), .FB(FRAC_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .o_ready   (i_in.ready),
        .i_op      (i_in.operation),
        .i_a_re    (i_in.a_re),
        .i_a_im    (i_in.a_im),
        .i_b_re    (i_in.b_re),
        .i_b_im    (i_in.b_im),
        .o_valid   (w_v[0]),
        .i_ready   (w_rdy[0]),
        .o_ctl     (w_ctl[0]),
        .o_res_re  (w_res_re[0]),
        .o_res_im  (w_res_im[0]),
        .o_drem_re (w_drem_re[0]),
        .o_drem_im (w_drem_im[0]),
        .o_den     (w_den[0]),
        .o_srem    (w_srem[0])
    );

    assign w_dq_re[0] = '0;
    assign w_dq_im[0] = '0;
    assign w_sroot[0] = '0;

    for (genvar k = 0; k < DW; k++) begin : g_cell
        cau_cell #(.DW(DW), .FB(FRAC_BITS), .BIT(DW - 1 - k)) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (w_v[k]),
            .o_ready   (w_rdy[k]),
            .i_ctl     (w_ctl[k]),
            .i_res_re  (w_res_re[k]),
            .i_res_im  (w_res_im[k]),
            .i_drem_re (w_drem_re[k]),
            .i_drem_im (w_drem_im[k]),
            .i_den     (w_den[k]),
            .i_dq_re   (w_dq_re[k]),
            .i_dq_im   (w_dq_im[k]),
            .i_srem    (w_srem[k]),
            .i_sroot   (w_sroot[k]),
            .o_valid   (w_v[k+1]),
            .i_ready   (w_rdy[k+1]),
            .o_ctl     (w_ctl[k+1]),
            .o_res_re  (w_res_re[k+1]),
            .o_res_im  (w_res_im[k+1]),
            .o_drem_re (w_drem_re[k+1]),
            .o_drem_im (w_drem_im[k+1]),
            .o_den     (w_den[k+1]),
            .o_dq_re   (w_dq_re[k+1]),
            .o_dq_im   (w_dq_im[k+1]),
            .o_srem    (w_srem[k+1]),
            .o_sroot   (w_sroot[k+1])
        );
    end

    t_ctl          n_ctl;
    logic [DW-1:0] n_q_re, n_q_im, n_root;
    logic          n_qov_re, n_qov_im, n_rov;
    logic [DW-1:0] n_div_re, n_div_im, n_mag;
    logic [DW-1:0] n_re, n_im;
    logic          n_truth, n_over;
    t_status       n_status;

    assign n_ctl  = w_ctl[DW];
    assign n_q_re = w_dq_re[DW];
    assign n_q_im = w_dq_im[DW];
    assign n_root = w_sroot[DW];

    assign n_qov_re = n_ctl.dovf_re || (n_ctl.neg_re ? (n_q_re[DW-1] && |n_q_re[DW-2:0])
                                                     : n_q_re[DW-1]);
    assign n_qov_im = n_ctl.dovf_im || (n_ctl.neg_im ? (n_q_im[DW-1] && |n_q_im[DW-2:0])
                                                     : n_q_im[DW-1]);
    assign n_div_re = n_qov_re ? (n_ctl.neg_re ? MINV : MAXV)
                               : (n_ctl.neg_re ? -n_q_re : n_q_re);
    assign n_div_im = n_qov_im ? (n_ctl.neg_im ? MINV : MAXV)
                               : (n_ctl.neg_im ? -n_q_im : n_q_im);
    assign n_rov    = n_root[DW-1];
    assign n_mag    = n_rov ? MAXV : n_root;

    always_comb begin
        n_re    = '0;
        n_im    = '0;
        n_truth = 1'b0;
        n_over  = 1'b0;
        case (n_ctl.op)
            OP_ADD, OP_SUB, OP_MUL: begin
                n_re   = w_res_re[DW];
                n_im   = w_res_im[DW];
                n_over = n_ctl.ovf;
            end
            OP_DIV: begin
                if (!n_ctl.dz) begin
                    n_re   = n_div_re;
                    n_im   = n_div_im;
                    n_over = n_qov_re || n_qov_im;
                end
            end
            OP_MAG: begin
                n_re   = n_mag;
                n_over = n_rov;
            end
            OP_LESS, OP_GREATER: n_truth = n_ctl.truth;
            default: begin
            end
        endcase
        if (n_over) begin
            n_status = ST_OVF;
        end else if (n_ctl.op == OP_DIV && n_ctl.dz) begin
            n_status = ST_DIV0;
        end else begin
            n_status = ST_OK;
        end
    end

    logic            r_ov;
    logic [DW-1:0]   r_o_re, r_o_im;
    logic            r_o_truth;
    t_status         r_o_status;

    assign w_rdy[DW] = !r_ov || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_rdy[DW]) begin
            r_ov <= w_v[DW];
        end
        if (w_v[DW] && w_rdy[DW]) begin
            r_o_re     <= n_re;
            r_o_im     <= n_im;
            r_o_truth  <= n_truth;
            r_o_status <= n_status;
        end
    end

    assign o_out.valid  = r_ov;
    assign o_out.res_re = r_o_re;
    assign o_out.res_im = r_o_im;
    assign o_out.truth  = r_o_truth;
    assign o_out.status = r_o_status;

    a_div0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_status == ST_DIV0) |-> (r_o_re == '0 && r_o_im == '0))
        else $error("divide-by-zero result carries nonzero parts");

    a_truth_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_truth) |-> (r_o_re == '0 && r_o_im == '0 && r_o_status == ST_OK))
        else $error("comparison result carries data or status");

    a_last_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_v[DW] && !w_rdy[DW]) |=> (w_v[DW] && $stable(w_sroot[DW])))
        else $error("last cell dropped a stalled item");

endmodule

[dv/tb_complex_arith_unit_core.sv]
// Testbench for the complex arithmetic unit: random and directed operand transfers,
// a built-in predictor and an in-order result scoreboard.
// Depends on cau_pkg, cau_in_if, cau_out_if and complex_arith_unit_core.
module tb_complex_arith_unit_core;
    import cau_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam logic [63:0] MAXPOS = 64'h7FFF_FFFF;
    localparam logic [63:0] MINMAG = 64'h8000_0000;

    typedef struct {
        logic [OP_W-1:0] op;
        logic [DW-1:0]   ar, ai, br, bi;
    } t_operands;

    typedef struct {
        logic [DW-1:0]   re, im;
        logic            truth;
        logic [ST_W-1:0] status;
    } t_answer;

    typedef struct {
        logic        neg;
        logic [63:0] mag;
    } t_sm;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   n_errors = 0;

    t_operands pending_ops[$];
    t_answer   expected_answers[$];
    bit        stim_done = 1'b0;

    cau_in_if  #(.DW(DW)) in_ch();
    cau_out_if #(.DW(DW)) out_ch();

    complex_arith_unit_core #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_sm to_sm(logic [DW-1:0] raw);
        t_sm r;
        r.neg = raw[DW-1];
        r.mag = r.neg ? {32'd0, -raw} : {32'd0, raw};
        return r;
    endfunction

    function automatic t_sm sm_mul(t_sm x, t_sm y);
        t_sm r;
        r.mag = x.mag * y.mag;
        r.neg = (x.neg != y.neg) && r.mag != 0;
        return r;
    endfunction

    function automatic t_sm sm_add(t_sm x, t_sm y);
        t_sm r;
        if (x.neg == y.neg) begin
            r.neg = x.neg;
            r.mag = x.mag + y.mag;
        end else if (x.mag >= y.mag) begin
            r.neg = x.neg;
            r.mag = x.mag - y.mag;
        end else begin
            r.neg = y.neg;
            r.mag = y.mag - x.mag;
        end
        if (r.mag == 0) r.neg = 1'b0;
        return r;
    endfunction

    function automatic t_sm sm_neg(t_sm x);
        x.neg = !x.neg && x.mag != 0;
        return x;
    endfunction

    function automatic logic [DW-1:0] clamp(t_sm v, inout logic over);
        if (!v.neg) begin
            if (v.mag > MAXPOS) begin
                over = 1'b1;
                return MAXPOS[DW-1:0];
            end
            return v.mag[DW-1:0];
        end
        if (v.mag > MINMAG) begin
            over = 1'b1;
            return MINMAG[DW-1:0];
        end
        return -v.mag[DW-1:0];
    endfunction

    function automatic t_sm floor_shift(t_sm v);
        t_sm r;
        r.neg = v.neg;
        r.mag = v.mag >> FB;
        if (v.neg && v.mag[FB-1:0] != 0) r.mag += 1;
        if (r.mag == 0) r.neg = 1'b0;
        return r;
    endfunction

    function automatic t_sm fixed_div(t_sm num, logic [63:0] den, inout logic over);
        t_sm         r;
        logic [63:0] q;
        logic [63:0] rem;
        logic        b;
        q = num.mag / den;
        rem = num.mag % den;
        r.neg = num.neg;
        if ((q >> (DW - FB)) != 0) begin
            over = 1'b1;
            r.mag = MINMAG + 1;
            return r;
        end
        for (int i = 0; i < FB; i++) begin
            b = rem >= den - rem;
            rem = b ? rem - (den - rem) : rem + rem;
            q = (q << 1) | b;
        end
        r.mag = q;
        if (q == 0) r.neg = 1'b0;
        return r;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic t_answer complex_result(t_operands x);
        t_answer     e;
        t_sm         ar, ai, br, bi, m;
        logic        over;
        logic [63:0] sa, sb;
        ar = to_sm(x.ar);
        ai = to_sm(x.ai);
        br = to_sm(x.br);
        bi = to_sm(x.bi);
        over = 1'b0;
        e = '{re: '0, im: '0, truth: 1'b0, status: ST_OK};
        sa = ar.mag * ar.mag + ai.mag * ai.mag;
        sb = br.mag * br.mag + bi.mag * bi.mag;
        case (x.op)
            OP_ADD: begin
                e.re = clamp(sm_add(ar, br), over);
                e.im = clamp(sm_add(ai, bi), over);
            end
            OP_SUB: begin
                e.re = clamp(sm_add(ar, sm_neg(br)), over);
                e.im = clamp(sm_add(ai, sm_neg(bi)), over);
            end
            OP_MUL: begin
                e.re = clamp(floor_shift(sm_add(sm_mul(ar, br), sm_neg(sm_mul(ai, bi)))), over);
                e.im = clamp(floor_shift(sm_add(sm_mul(ar, bi), sm_mul(br, ai))), over);
            end
            OP_DIV: begin
                if (sb == 0) begin
                    e.status = ST_DIV0;
                end else begin
                    e.re = clamp(fixed_div(sm_add(sm_mul(ar, br), sm_mul(ai, bi)), sb, over),
                                 over);
                    e.im = clamp(fixed_div(sm_add(sm_mul(br, ai), sm_neg(sm_mul(ar, bi))), sb,
                                           over), over);
                end
            end
            OP_MAG: begin
                m.neg = 1'b0;
                m.mag = int_sqrt(sa);
                e.re = clamp(m, over);
            end
            OP_LESS:    e.truth = sa < sb;
            OP_GREATER: e.truth = sb < sa;
            default: ;
        endcase
        if (over) e.status = ST_OVF;
        return e;
    endfunction

    function automatic logic [DW-1:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3, 4: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            5, 6: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [DW-1:0] got, logic [DW-1:0] want);
        $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
        n_errors++;
    endtask

    task automatic queue_item(logic [OP_W-1:0] op, logic [DW-1:0] ar, logic [DW-1:0] ai,
                              logic [DW-1:0] br, logic [DW-1:0] bi);
        t_operands x;
        x = '{op: op, ar: ar, ai: ai, br: br, bi: bi};
        pending_ops.push_back(x);
    endtask

    initial begin
        logic [DW-1:0] ext[4];
        ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF};
        for (int op = 0; op < 8; op++) begin
            queue_item(OP_W'(op), ext[0], ext[1], ext[1], ext[0]);
            queue_item(OP_W'(op), ext[1], ext[3], 32'h0001_0000, 32'd0);
        end
        queue_item(OP_DIV, 32'h0003_0000, 32'h0001_0000, 32'd0, 32'd0);
        queue_item(OP_DIV, 32'h7FFF_FFFF, 32'd0, 32'd1, 32'd0);
        queue_item(OP_MAG, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
        queue_item(OP_LESS, 32'h0003_0000, 32'h0004_0000, 32'h0004_0000, 32'h0003_0000);
        queue_item(OP_GREATER, 32'hFFFD_0000, 32'h0004_0000, 32'h0004_0000, 32'h0003_0000);
        queue_item(OP_MUL, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1);
        for (int i = 0; i < 1750; i++) begin
            queue_item(OP_W'($urandom_range(0, 7)), rand_operand(), rand_operand(),
                       rand_operand(), rand_operand());
        end
        stim_done = 1'b1;
    end

    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_ch.valid <= 1'b0;
            end else if (pending_ops.size() != 0) begin
                t_operands x;
                x = pending_ops.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.operation <= x.op;
                in_ch.a_re <= x.ar;
                in_ch.a_im <= x.ai;
                in_ch.b_re <= x.br;
                in_ch.b_im <= x.bi;
                expected_answers.push_back(complex_result(x));
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    int stall_phase = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            stall_phase <= (stall_phase + 1) % 97;
            out_ch.ready <= (stall_phase < 40) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_answers.size() == 0) begin
                $display("ERROR %0t: result transfer with nothing expected", $realtime);
                n_errors++;
            end else begin
                t_answer e;
                e = expected_answers.pop_front();
                if (out_ch.res_re !== e.re) report_mismatch("res_re", out_ch.res_re, e.re);
                if (out_ch.res_im !== e.im) report_mismatch("res_im", out_ch.res_im, e.im);
                if (out_ch.truth !== e.truth) begin
                    report_mismatch("truth", DW'(out_ch.truth), DW'(e.truth));
                end
                if (out_ch.status !== e.status) begin
                    report_mismatch("status", DW'(out_ch.status), DW'(e.status));
                end
            end
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.operation = '0;
        in_ch.a_re = '0;
        in_ch.a_im = '0;
        in_ch.b_re = '0;
        in_ch.b_im = '0;
        out_ch.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && pending_ops.size() == 0 && expected_answers.size() == 0);
        repeat (2 * DW + 20) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
